### rtl/core/cptp_pkg.sv
package cptp_pkg;

    // Default table size and counter width
    localparam int NUM_TASKS_DEF    = 16;
    localparam int COUNTER_BITS_DEF = 16;

    // Item kinds carried on s_tuser
    localparam logic [1:0] KIND_LOAD     = 2'd0;
    localparam logic [1:0] KIND_SIGNAL   = 2'd1;
    localparam logic [1:0] KIND_SCHEDULE = 2'd2;

    // Task status codes
    localparam logic [2:0] ST_RUNNABLE      = 3'd1;
    localparam logic [2:0] ST_RUNNING       = 3'd2;
    localparam logic [2:0] ST_INTERRUPTIBLE = 3'd3;

    // Highest signal number that can be posted
    localparam logic [5:0] SIG_LIMIT = 6'd32;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGNAL,
        S_WAKE,
        S_RECHARGE,
        S_FINISH,
        S_DONE
    } state_t;

    // Per-field write enables into the task table
    typedef struct packed {
        logic used;
        logic id;
        logic status;
        logic counter;
        logic prio;
        logic mask;
    } tbl_wen_t;

endpackage

### rtl/core/cptp_table.sv
module cptp_table #(
    parameter int NUM_TASKS    = cptp_pkg::NUM_TASKS_DEF,
    parameter int COUNTER_BITS = cptp_pkg::COUNTER_BITS_DEF,
    parameter int IDX_W        = $clog2(NUM_TASKS)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [IDX_W-1:0]        rd_addr,
    input  cptp_pkg::tbl_wen_t      wen,
    input  logic [IDX_W-1:0]        wr_addr,
    input  logic                    wr_used,
    input  logic [15:0]             wr_id,
    input  logic [2:0]              wr_status,
    input  logic [COUNTER_BITS-1:0] wr_counter,
    input  logic [7:0]              wr_prio,
    input  logic [31:0]             wr_mask,
    output logic                    rd_used,
    output logic [15:0]             rd_id,
    output logic [2:0]              rd_status,
    output logic [COUNTER_BITS-1:0] rd_counter,
    output logic [7:0]              rd_prio,
    output logic [31:0]             rd_mask
);
    import cptp_pkg::*;

    // Used bits live in flip-flops so that reset empties the table at once
    logic [NUM_TASKS-1:0] used_reg;

    // Remaining fields are plain memories, undefined until loaded
    logic [15:0]             id_mem      [NUM_TASKS];
    logic [2:0]              status_mem  [NUM_TASKS];
    logic [COUNTER_BITS-1:0] counter_mem [NUM_TASKS];
    logic [7:0]              prio_mem    [NUM_TASKS];
    logic [31:0]             mask_mem    [NUM_TASKS];

    logic                    rd_used_reg;
    logic [15:0]             rd_id_reg;
    logic [2:0]              rd_status_reg;
    logic [COUNTER_BITS-1:0] rd_counter_reg;
    logic [7:0]              rd_prio_reg;
    logic [31:0]             rd_mask_reg;

    // Update used bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (wen.used)
        begin
            used_reg[wr_addr] <= wr_used;
        end
    end

    // Write the field memories
    always_ff @(posedge clk)
    begin
        if (wen.id)
        begin
            id_mem[wr_addr] <= wr_id;
        end
        if (wen.status)
        begin
            status_mem[wr_addr] <= wr_status;
        end
        if (wen.counter)
        begin
            counter_mem[wr_addr] <= wr_counter;
        end
        if (wen.prio)
        begin
            prio_mem[wr_addr] <= wr_prio;
        end
        if (wen.mask)
        begin
            mask_mem[wr_addr] <= wr_mask;
        end
    end

    // Registered read of one entry per cycle
    always_ff @(posedge clk)
    begin
        rd_used_reg    <= used_reg[rd_addr];
        rd_id_reg      <= id_mem[rd_addr];
        rd_status_reg  <= status_mem[rd_addr];
        rd_counter_reg <= counter_mem[rd_addr];
        rd_prio_reg    <= prio_mem[rd_addr];
        rd_mask_reg    <= mask_mem[rd_addr];
    end

    assign rd_used    = rd_used_reg;
    assign rd_id      = rd_id_reg;
    assign rd_status  = rd_status_reg;
    assign rd_counter = rd_counter_reg;
    assign rd_prio    = rd_prio_reg;
    assign rd_mask    = rd_mask_reg;

endmodule

### rtl/core/counter_priority_task_picker.sv
// Counter-based task picker. A table of NUM_TASKS task slots (pid, status,
// time counter, priority, pending-signal mask) is written by load
// transactions, updated by signal transactions and scanned by schedule
// transactions, which wake interruptible tasks with pending signals, pick the
// runnable task with the largest counter (lowest slot on a tie), recharge the
// counters of all used slots by priority when the best counter is zero, pick
// again and mark the pick running. Every input transaction gives exactly one
// output transaction; only schedule results carry non-zero fields. The table
// is read through a single port, one slot per cycle, and each scan pass reads
// every slot in turn. The block takes one input transaction at a time and
// holds s_tready low while it works.
module counter_priority_task_picker #(
    parameter int NUM_TASKS    = cptp_pkg::NUM_TASKS_DEF,
    parameter int COUNTER_BITS = cptp_pkg::COUNTER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[3:0], entry_used[4], pid[20:5], entry_status[23:21],
    // entry_counter[39:24], entry_priority[47:40], entry_signals[79:48],
    // signal_number[85:80], zero fill [87:86]
    input  logic [87:0] s_tdata,
    // kind[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // chosen_slot[3:0], chose_idle[4], recharged[5], stuck[6], zero fill [7]
    output logic [7:0]  m_tdata
);
    import cptp_pkg::*;

    localparam int IDX_W = $clog2(NUM_TASKS);
    localparam int SUM_W = ((COUNTER_BITS > 8) ? COUNTER_BITS : 8) + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

    // Input fields
    logic [3:0]  slot_in;
    logic        used_in;
    logic [15:0] pid_in;
    logic [2:0]  status_in;
    logic [15:0] counter_in;
    logic [7:0]  prio_in;
    logic [31:0] signals_in;
    logic [5:0]  signo_in;
    logic        accept;
    logic        sig_ok;

    assign slot_in    = s_tdata[3:0];
    assign used_in    = s_tdata[4];
    assign pid_in     = s_tdata[20:5];
    assign status_in  = s_tdata[23:21];
    assign counter_in = s_tdata[39:24];
    assign prio_in    = s_tdata[47:40];
    assign signals_in = s_tdata[79:48];
    assign signo_in   = s_tdata[85:80];

    assign accept = s_tvalid && s_tready;
    assign sig_ok = (signo_in >= 6'd1) && (signo_in <= SIG_LIMIT);

    // Sequencer and datapath registers
    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    iss_reg, iss_next;
    logic                    pv_reg, pv_next;
    logic [IDX_W-1:0]        pidx_reg, pidx_next;
    logic [IDX_W-1:0]        best_reg, best_next;
    logic                    bvld_reg, bvld_next;
    logic [COUNTER_BITS-1:0] top_reg, top_next;
    logic                    rech_reg, rech_next;
    logic                    stuck_reg, stuck_next;
    logic                    idle_reg, idle_next;
    logic [3:0]              chosen_reg, chosen_next;
    logic [15:0]             pid_reg, pid_next;
    logic [31:0]             sbit_reg, sbit_next;
    logic                    mvalid_reg, mvalid_next;
    logic [7:0]              mdata_reg, mdata_next;

    // Table ports
    tbl_wen_t                wen;
    logic [IDX_W-1:0]        wr_addr;
    logic                    wr_used;
    logic [15:0]             wr_id;
    logic [2:0]              wr_status;
    logic [COUNTER_BITS-1:0] wr_counter;
    logic [7:0]              wr_prio;
    logic [31:0]             wr_mask;
    logic                    rd_used;
    logic [15:0]             rd_id;
    logic [2:0]              rd_status;
    logic [COUNTER_BITS-1:0] rd_counter;
    logic [7:0]              rd_prio;
    logic [31:0]             rd_mask;

    // Scan helpers
    logic                    pass_end;
    logic [2:0]              eff_status;
    logic [SUM_W-1:0]        sum;
    logic [COUNTER_BITS-1:0] new_counter;

    cptp_table #(
        .NUM_TASKS    (NUM_TASKS),
        .COUNTER_BITS (COUNTER_BITS),
        .IDX_W        (IDX_W)
    ) u_table (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_addr    (idx_reg),
        .wen        (wen),
        .wr_addr    (wr_addr),
        .wr_used    (wr_used),
        .wr_id      (wr_id),
        .wr_status  (wr_status),
        .wr_counter (wr_counter),
        .wr_prio    (wr_prio),
        .wr_mask    (wr_mask),
        .rd_used    (rd_used),
        .rd_id      (rd_id),
        .rd_status  (rd_status),
        .rd_counter (rd_counter),
        .rd_prio    (rd_prio),
        .rd_mask    (rd_mask)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign pass_end = pv_reg && (pidx_reg == LAST_IDX);

    // Saturating recharge of the slot under scan
    always_comb
    begin
        sum = SUM_W'(rd_counter) + SUM_W'(rd_prio);
        if (sum[SUM_W-1:COUNTER_BITS] != '0)
        begin
            new_counter = '1;
        end
        else
        begin
            new_counter = sum[COUNTER_BITS-1:0];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == KIND_SCHEDULE)
                    begin
                        state_next = S_WAKE;
                    end
                    else if (s_tuser == KIND_SIGNAL && sig_ok)
                    begin
                        state_next = S_SIGNAL;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SIGNAL:
            begin
                if (pass_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_WAKE:
            begin
                if (pass_end)
                begin
                    state_next = rech_next ? S_RECHARGE : S_FINISH;
                end
            end
            S_RECHARGE:
            begin
                if (pass_end)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, table writes and result
    always_comb
    begin
        idx_next    = idx_reg;
        iss_next    = iss_reg;
        pv_next     = 1'b0;
        pidx_next   = pidx_reg;
        best_next   = best_reg;
        bvld_next   = bvld_reg;
        top_next    = top_reg;
        rech_next   = rech_reg;
        stuck_next  = stuck_reg;
        idle_next   = idle_reg;
        chosen_next = chosen_reg;
        pid_next    = pid_reg;
        sbit_next   = sbit_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        eff_status  = rd_status;

        wen        = '0;
        wr_addr    = pidx_reg;
        wr_used    = used_in;
        wr_id      = pid_in;
        wr_status  = status_in;
        wr_counter = COUNTER_BITS'(counter_in);
        wr_prio    = prio_in;
        wr_mask    = rd_mask | sbit_reg;

        // Drop the result once taken
        if (m_tready)
        begin
            mvalid_next = 1'b0;
        end

        // Advance the read address through the table
        if (iss_reg)
        begin
            pv_next   = 1'b1;
            pidx_next = idx_reg;
            if (idx_reg == LAST_IDX)
            begin
                iss_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rech_next   = 1'b0;
                    stuck_next  = 1'b0;
                    idle_next   = 1'b0;
                    chosen_next = '0;
                    pid_next    = pid_in;
                    sbit_next   = 32'd1 << 5'(signo_in - 6'd1);
                    if (s_tuser == KIND_LOAD && {28'd0, slot_in} < 32'(NUM_TASKS))
                    begin
                        wen     = '1;
                        wr_addr = IDX_W'(slot_in);
                        wr_mask = signals_in;
                    end
                    if (s_tuser == KIND_SCHEDULE || (s_tuser == KIND_SIGNAL && sig_ok))
                    begin
                        idx_next  = '0;
                        iss_next  = 1'b1;
                        bvld_next = 1'b0;
                        top_next  = '0;
                    end
                end
            end
            S_SIGNAL:
            begin
                // Post the signal to every used slot with the target pid
                if (pv_reg && rd_used && rd_id == pid_reg)
                begin
                    wen.mask = 1'b1;
                end
            end
            S_WAKE:
            begin
                if (pv_reg)
                begin
                    // Wake interruptible tasks with pending signals
                    if (rd_used && rd_mask != '0 && rd_status == ST_INTERRUPTIBLE)
                    begin
                        wen.status = 1'b1;
                        wr_status  = ST_RUNNABLE;
                        eff_status = ST_RUNNABLE;
                    end
                    // Keep the best runnable counter, first slot wins a tie
                    if (rd_used && eff_status == ST_RUNNABLE &&
                        (!bvld_reg || rd_counter > top_reg))
                    begin
                        bvld_next = 1'b1;
                        best_next = pidx_reg;
                        top_next  = rd_counter;
                    end
                end
                if (pass_end && bvld_next && top_next == '0)
                begin
                    rech_next = 1'b1;
                    idx_next  = '0;
                    iss_next  = 1'b1;
                    bvld_next = 1'b0;
                    top_next  = '0;
                end
            end
            S_RECHARGE:
            begin
                if (pv_reg && rd_used)
                begin
                    wen.counter = 1'b1;
                    wr_counter  = new_counter;
                    if (rd_status == ST_RUNNABLE && (!bvld_reg || new_counter > top_reg))
                    begin
                        bvld_next = 1'b1;
                        best_next = pidx_reg;
                        top_next  = new_counter;
                    end
                end
                if (pass_end && bvld_next && top_next == '0)
                begin
                    stuck_next = 1'b1;
                end
            end
            S_FINISH:
            begin
                // Mark the pick running, or fall back to idle
                if (bvld_reg && !stuck_reg)
                begin
                    wen.status  = 1'b1;
                    wr_addr     = best_reg;
                    wr_status   = ST_RUNNING;
                    chosen_next = 4'(best_reg);
                    idle_next   = 1'b0;
                end
                else
                begin
                    chosen_next = '0;
                    idle_next   = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = {1'b0, stuck_reg, rech_reg, idle_reg, chosen_reg};
                end
            end
            default:
            begin
                wen = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            iss_reg    <= 1'b0;
            pv_reg     <= 1'b0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            iss_reg    <= iss_next;
            pv_reg     <= pv_next;
            mvalid_reg <= mvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pidx_reg   <= pidx_next;
        best_reg   <= best_next;
        bvld_reg   <= bvld_next;
        top_reg    <= top_next;
        rech_reg   <= rech_next;
        stuck_reg  <= stuck_next;
        idle_reg   <= idle_next;
        chosen_reg <= chosen_next;
        pid_reg    <= pid_next;
        sbit_reg   <= sbit_next;
        mdata_reg  <= mdata_next;
    end

`ifndef NO_ASSERTIONS
    // A stuck schedule has always recharged and run idle
    a_stuck_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[6] |-> m_tdata[5] && m_tdata[4])
        else $error("stuck result without recharge and idle");

    // Idle results carry slot zero
    a_idle_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[3:0] == 4'd0)
        else $error("idle result with non-zero slot");

    // Table reads are only in flight during a scan pass
    a_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
        pv_reg |-> state_reg == S_SIGNAL || state_reg == S_WAKE ||
                   state_reg == S_RECHARGE)
        else $error("table read outside a scan pass");

    // The sequencer leaves idle after every accepted input transaction
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("sequencer did not leave idle after an input transaction");
`endif

endmodule

### verif/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cptp_pkg::*;

    localparam int          TABLE_SIZE  = NUM_TASKS_DEF;
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          DRAIN_WAIT  = 64;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [1:0]  KIND_NONE   = 2'd3;
    localparam logic [2:0]  ST_EMBRYO          = 3'd0;
    localparam logic [2:0]  ST_UNINTERRUPTIBLE = 3'd4;
    localparam logic [2:0]  ST_ZOMBIE          = 3'd5;
    localparam logic [2:0]  ST_UNKNOWN_LO      = 3'd6;
    localparam logic [2:0]  ST_UNKNOWN_HI      = 3'd7;

    // Result fields as they sit in m_tdata[6:0]
    typedef struct packed {
        logic       stuck;
        logic       recharged;
        logic       chose_idle;
        logic [3:0] chosen_slot;
    } pick_t;

    // Shadow task table and queue of expected schedule results
    class pick_scoreboard;
        logic        used [TABLE_SIZE];
        logic [15:0] task_pid [TABLE_SIZE];
        logic [2:0]  task_state [TABLE_SIZE];
        logic [15:0] task_count [TABLE_SIZE];
        logic [7:0]  task_prio [TABLE_SIZE];
        logic [31:0] task_pending [TABLE_SIZE];
        pick_t       expected_picks [$];
        int          errors;

        function new();
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                used[i]         = 1'b0;
                task_pid[i]     = '0;
                task_state[i]   = '0;
                task_count[i]   = '0;
                task_prio[i]    = '0;
                task_pending[i] = '0;
            end
            errors = 0;
        endfunction

        // Find the runnable slot with the largest counter, lowest slot on a tie
        function int best_runnable(output logic [15:0] top);
            int best;
            best = -1;
            top  = '0;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                if (used[i] && task_state[i] == ST_RUNNABLE && (best < 0 || task_count[i] > top))
                begin
                    top  = task_count[i];
                    best = i;
                end
            end
            return best;
        endfunction

        // Apply one accepted transaction to the shadow table and queue its result
        function void note_item(logic [1:0] kind, logic [87:0] data);
            logic [3:0]  slot;
            logic [15:0] pid;
            logic [5:0]  signo;
            logic [15:0] top;
            logic [16:0] sum;
            int          best;
            pick_t       res;
            slot  = data[3:0];
            pid   = data[20:5];
            signo = data[85:80];
            res   = '0;
            case (kind)
                KIND_LOAD:
                begin
                    used[slot]         = data[4];
                    task_pid[slot]     = pid;
                    task_state[slot]   = data[23:21];
                    task_count[slot]   = data[39:24];
                    task_prio[slot]    = data[47:40];
                    task_pending[slot] = data[79:48];
                end
                KIND_SIGNAL:
                begin
                    if (signo >= 6'd1 && signo <= SIG_LIMIT)
                    begin
                        for (int i = 0; i < TABLE_SIZE; i++)
                        begin
                            if (used[i] && task_pid[i] == pid)
                                task_pending[i] = task_pending[i] | (32'd1 << (signo - 6'd1));
                        end
                    end
                end
                KIND_SCHEDULE:
                begin
                    // Wake interruptible tasks with pending signals
                    for (int i = 0; i < TABLE_SIZE; i++)
                    begin
                        if (used[i] && task_pending[i] != 0 && task_state[i] == ST_INTERRUPTIBLE)
                            task_state[i] = ST_RUNNABLE;
                    end
                    best = best_runnable(top);
                    // Recharge every used slot once when the best counter is zero
                    if (best >= 0 && top == 0)
                    begin
                        res.recharged = 1'b1;
                        for (int i = 0; i < TABLE_SIZE; i++)
                        begin
                            if (used[i])
                            begin
                                sum = {1'b0, task_count[i]} + {9'd0, task_prio[i]};
                                task_count[i] = sum[16] ? 16'hFFFF : sum[15:0];
                            end
                        end
                        best = best_runnable(top);
                        if (best >= 0 && top == 0)
                        begin
                            res.stuck = 1'b1;
                            best      = -1;
                        end
                    end
                    if (best < 0)
                        res.chose_idle = 1'b1;
                    else
                    begin
                        res.chosen_slot  = best[3:0];
                        task_state[best] = ST_RUNNING;
                    end
                end
                default: ;
            endcase
            expected_picks.push_back(res);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one result transaction with the oldest expectation
        function void check_pick(logic [7:0] bits);
            pick_t got;
            pick_t want;
            got = bits[6:0];
            if (expected_picks.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h", $time, bits);
                errors++;
            end
            else
            begin
                want = expected_picks.pop_front();
                compare_field("chosen_slot", want.chosen_slot, got.chosen_slot);
                compare_field("chose_idle", want.chose_idle, got.chose_idle);
                compare_field("recharged", want.recharged, got.recharged);
                compare_field("stuck", want.stuck, got.stuck);
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    pick_scoreboard sb;
    int             inputs_taken = 0;
    int             cycle_count  = 0;
    logic [15:0]    pid_pool [4] = '{16'h0000, 16'h0001, 16'h00A5, 16'hFFFF};

    counter_priority_task_picker dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Note accepted input transactions and check accepted results
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            sb.note_item(s_tuser, s_tdata);
            inputs_taken++;
        end
        if (rst_n && m_tvalid && m_tready)
            sb.check_pick(m_tdata);
    end

    function automatic logic [87:0] pack_item(logic [3:0] slot, logic used, logic [15:0] pid,
                                              logic [2:0] status, logic [15:0] counter,
                                              logic [7:0] prio, logic [31:0] sigs,
                                              logic [5:0] signo);
        return {2'b00, signo, sigs, prio, counter, status, pid, used, slot};
    endfunction

    // Offer one transaction from a falling edge; return at the falling edge after acceptance
    task automatic send_item(input logic [1:0] kind, input logic [87:0] data);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic send_load(input logic [3:0] slot, input logic used, input logic [15:0] pid,
                             input logic [2:0] status, input logic [15:0] counter,
                             input logic [7:0] prio, input logic [31:0] sigs);
        send_item(KIND_LOAD, pack_item(slot, used, pid, status, counter, prio, sigs, 6'd0));
    endtask

    task automatic post_signal(input logic [15:0] pid, input logic [5:0] signo);
        send_item(KIND_SIGNAL, pack_item(4'd0, 1'b0, pid, 3'd0, 16'd0, 8'd0, 32'd0, signo));
    endtask

    task automatic send_schedule();
        send_item(KIND_SCHEDULE, pack_item(4'd0, 1'b0, 16'd0, 3'd0, 16'd0, 8'd0, 32'd0, 6'd0));
    endtask

    // Mostly well-formed task tables over a small pid pool, with some noise
    task automatic send_random(input int count);
        int          sent;
        int          burst;
        int          r;
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic        used;
        logic [15:0] pid;
        logic [2:0]  status;
        logic [15:0] counter;
        logic [7:0]  prio;
        logic [31:0] sigs;
        logic [5:0]  signo;
        sent = 0;
        while (sent < count)
        begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            for (int b = 0; b < burst; b++)
            begin
                r = $urandom_range(0, 99);
                kind = (r < 38) ? KIND_LOAD : (r < 62) ? KIND_SIGNAL :
                       (r < 93) ? KIND_SCHEDULE : KIND_NONE;
                slot = 4'($urandom);
                used = ($urandom_range(0, 7) != 0);
                pid  = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                       pid_pool[$urandom_range(0, 3)];
                r = $urandom_range(0, 9);
                status = (r < 4) ? ST_RUNNABLE : (r < 6) ? ST_INTERRUPTIBLE :
                         (r < 7) ? ST_RUNNING : 3'($urandom_range(0, 7));
                r = $urandom_range(0, 9);
                counter = (r < 6) ? 16'($urandom_range(0, 3)) :
                          (r < 8) ? 16'($urandom_range(65280, 65535)) : 16'($urandom);
                r = $urandom_range(0, 9);
                prio = (r < 3) ? 8'd0 : (r < 7) ? 8'($urandom_range(1, 4)) :
                       (r < 8) ? 8'hFF : 8'($urandom);
                sigs = $urandom_range(0, 1) ? 32'd0 :
                       $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 31)) : $urandom;
                signo = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) :
                        6'($urandom_range(1, 32));
                send_item(kind, pack_item(slot, used, pid, status, counter, prio, sigs, signo));
                if (kind != KIND_NONE)
                    sent++;
            end
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    // Receiver: alternate stall patterns, with one long hold-off to fill the block
    initial
    begin
        int mode;
        int seg;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!held && inputs_taken >= 300)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            mode = $urandom_range(0, 2);
            seg  = $urandom_range(10, 80);
            for (int i = 0; i < seg; i++)
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (i % 4 != 0);
                endcase
                @(negedge clk);
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        sb = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table: idle
        send_schedule();
        // Single runnable task with zero counter and zero priority: stuck
        send_load(4'd0, 1'b1, 16'h0000, ST_RUNNABLE, 16'h0000, 8'h00, 32'h0);
        send_schedule();
        // Field extremes
        send_load(4'd15, 1'b1, 16'hFFFF, ST_RUNNABLE, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
        send_load(4'd3, 1'b1, 16'h0001, ST_INTERRUPTIBLE, 16'hFFFF, 8'h00, 32'h0);
        // Signal numbers outside the valid range are dropped
        post_signal(16'h0001, 6'd0);
        post_signal(16'h0001, 6'd33);
        post_signal(16'h0001, 6'd63);
        send_schedule();
        // Valid signal numbers at both ends wake the sleeping task
        post_signal(16'h0001, SIG_LIMIT);
        post_signal(16'h0001, 6'd1);
        send_schedule();
        // Unknown statuses, an unused slot and a tie after recharge
        send_load(4'd5, 1'b1, 16'h0002, ST_UNKNOWN_LO, 16'h0000, 8'h05, 32'h1);
        send_load(4'd6, 1'b1, 16'h0002, ST_UNKNOWN_HI, 16'h0000, 8'h05, 32'h1);
        send_load(4'd7, 1'b0, 16'h0002, ST_RUNNABLE, 16'h0009, 8'h05, 32'h0);
        send_load(4'd8, 1'b1, 16'h0003, ST_RUNNABLE, 16'h0000, 8'hFF, 32'h0);
        send_load(4'd9, 1'b1, 16'h0003, ST_RUNNABLE, 16'h0000, 8'hFF, 32'h0);
        send_schedule();
        // Remaining statuses and an unknown kind
        send_load(4'd10, 1'b1, 16'h0004, ST_ZOMBIE, 16'h0064, 8'h01, 32'h0);
        send_load(4'd11, 1'b1, 16'h0004, ST_EMBRYO, 16'h0064, 8'h01, 32'h0);
        send_load(4'd12, 1'b1, 16'h0004, ST_UNINTERRUPTIBLE, 16'h0064, 8'h01, 32'h2);
        send_item(KIND_NONE, {2'b00, 54'($urandom), $urandom});
        send_schedule();
        // Clear a slot
        send_load(4'd0, 1'b0, 16'h0000, ST_RUNNABLE, 16'h0000, 8'h00, 32'h0);
        send_schedule();

        send_random(750);

        s_tvalid <= 1'b0;
        while (sb.expected_picks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
